>>> design/sha1_pkg.sv
// ----------------------------------------------------------------------------
// SHA-1 engine package
// Shared types and constants for the SHA-1 hash engine and its round unit.
// ----------------------------------------------------------------------------
package sha1_pkg;

	localparam int unsigned WORD_W = 32;
	localparam int unsigned ROUND_W = 7;

	// Five 32-bit words a..e, used for both the chaining value and the round state
	typedef struct packed {
		logic [WORD_W-1:0] a;
		logic [WORD_W-1:0] b;
		logic [WORD_W-1:0] c;
		logic [WORD_W-1:0] d;
		logic [WORD_W-1:0] e;
	} work_t;

	localparam logic [WORD_W-1:0] K_00_19 = 32'h5A827999;
	localparam logic [WORD_W-1:0] K_20_39 = 32'h6ED9EBA1;
	localparam logic [WORD_W-1:0] K_40_59 = 32'h8F1BBCDC;
	localparam logic [WORD_W-1:0] K_60_79 = 32'hCA62C1D6;

	localparam work_t H_INIT = '{
		a: 32'h67452301,
		b: 32'hEFCDAB89,
		c: 32'h98BADCFE,
		d: 32'h10325476,
		e: 32'hC3D2E1F0
	};

	localparam logic [7:0] PAD_BYTE = 8'h80;

	localparam logic [ROUND_W-1:0] ROUND_SCHED = 7'd16;
	localparam logic [ROUND_W-1:0] ROUND_B1 = 7'd20;
	localparam logic [ROUND_W-1:0] ROUND_B2 = 7'd40;
	localparam logic [ROUND_W-1:0] ROUND_B3 = 7'd60;
	localparam logic [ROUND_W-1:0] ROUND_LAST = 7'd79;

endpackage

>>> design/sha1_round.sv
// ----------------------------------------------------------------------------
// SHA-1 round unit
// One compression round: selects f and K by round number and forms the next
// a..e from the current state and the schedule word.
// ----------------------------------------------------------------------------
module sha1_round (
	input  sha1_pkg::work_t                    cur,
	input  logic [sha1_pkg::WORD_W-1:0]        w,
	input  logic [sha1_pkg::ROUND_W-1:0]       round,
	output sha1_pkg::work_t                    nxt
);

	logic [sha1_pkg::WORD_W-1:0] f;
	logic [sha1_pkg::WORD_W-1:0] k;
	logic [sha1_pkg::WORD_W-1:0] a_rot;

	always_comb begin
		if (round < sha1_pkg::ROUND_B1) begin
			f = (cur.b & cur.c) | (~cur.b & cur.d);
			k = sha1_pkg::K_00_19;
		end else if (round < sha1_pkg::ROUND_B2) begin
			f = cur.b ^ cur.c ^ cur.d;
			k = sha1_pkg::K_20_39;
		end else if (round < sha1_pkg::ROUND_B3) begin
			f = (cur.b & cur.c) | (cur.b & cur.d) | (cur.c & cur.d);
			k = sha1_pkg::K_40_59;
		end else begin
			f = cur.b ^ cur.c ^ cur.d;
			k = sha1_pkg::K_60_79;
		end
	end

	assign a_rot = {cur.a[26:0], cur.a[31:27]};

	always_comb begin
		nxt.a = a_rot + f + cur.e + k + w;
		nxt.b = cur.a;
		nxt.c = {cur.b[1:0], cur.b[31:2]};
		nxt.d = cur.c;
		nxt.e = cur.d;
	end

endmodule

>>> design/sha1_hash_engine.sv
// ----------------------------------------------------------------------------
// SHA-1 hash engine
// Byte-serial SHA-1 with an iterative round unit and an on-chip padder.
// ----------------------------------------------------------------------------
// Input channel s_*: one item per byte. s_tuser is the command: 0 absorbs
// s_tdata into the message, 1 finishes the message. Output channel m_*: five
// digest words, H0 first; m_tdata carries the word and its index, m_tlast
// marks the fifth word.
// Data bytes are taken while s_tready is high; the 64th byte of a block starts
// the compression: 80 rounds through the single round unit, one per cycle,
// then an add into the chaining value, with s_tready held low throughout.
// A finish generates the padding internally (up to 72 bytes), one byte per cycle
// outside compression, compresses one or two blocks, then offers the five digest words.
// The words are held while m_tready is low; s_tready stays low until the
// last word is taken, after which the engine is ready for a new message.
// Reset (arst_n low) loads the initial hash values and clears the byte count
// and message length; the block buffer itself is not cleared.
// ----------------------------------------------------------------------------
module sha1_hash_engine (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tuser,   // [0] cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [31:0] digest_word, [34:32] word_index, [39:35] zero
	output logic        m_tlast
);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_ROUND = 5'b00010,
		ST_ADD   = 5'b00100,
		ST_PAD   = 5'b01000,
		ST_EMIT  = 5'b10000
	} state_t;

	localparam logic [2:0] WORD_IDX_LAST = 3'd4;
	localparam logic [5:0] FILL_LEN = 6'd56;
	localparam logic [5:0] FILL_LAST = 6'd63;

	state_t                          state_q;
	logic [5:0]                      fill_q;
	logic [63:0]                     msg_bits_q;
	logic [sha1_pkg::ROUND_W-1:0]    round_q;
	logic [2:0]                      emit_idx_q;
	logic [511:0]                    blk_q;
	sha1_pkg::work_t                 chain_q;
	sha1_pkg::work_t                 work_q;
	sha1_pkg::work_t                 work_nxt;
	logic                            fin_q;
	logic                            first_q;
	logic                            len_q;
	logic                            pad_done_q;

	logic                            take;
	logic                            in_len;
	logic                            pad_last;
	logic [7:0]                      len_byte;
	logic [7:0]                      pad_byte;
	logic                            byte_go;
	logic [7:0]                      byte_val;
	logic [sha1_pkg::WORD_W-1:0]     xw;
	logic [sha1_pkg::WORD_W-1:0]     sched_w;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = (state_q == ST_EMIT);
	assign m_tdata  = {5'b0, emit_idx_q, chain_q.a};
	assign m_tlast  = (emit_idx_q == WORD_IDX_LAST);

	assign take = s_tvalid && s_tready;

	// Length bytes start once the zero fill reaches byte 56 of a block
	assign in_len   = len_q || (!first_q && fill_q == FILL_LEN);
	assign pad_last = in_len && fill_q == FILL_LAST;
	assign len_byte = msg_bits_q[{~fill_q[2:0], 3'b000} +: 8];
	assign pad_byte = first_q ? sha1_pkg::PAD_BYTE : (in_len ? len_byte : 8'h00);

	assign byte_go  = (take && !s_tuser) || (state_q == ST_PAD);
	assign byte_val = (state_q == ST_PAD) ? pad_byte : s_tdata;

	// Block buffer doubles as the 16-word schedule window, oldest word on top
	assign xw      = blk_q[95:64] ^ blk_q[255:224] ^ blk_q[447:416] ^ blk_q[511:480];
	assign sched_w = (round_q < sha1_pkg::ROUND_SCHED) ? blk_q[511:480]
	                                                   : {xw[30:0], xw[31]};

	sha1_round u_round (
		.cur   (work_q),
		.w     (sched_w),
		.round (round_q),
		.nxt   (work_nxt)
	);

	always_ff @(posedge clk) begin
		if (byte_go) begin
			blk_q <= {blk_q[503:0], byte_val};
		end else if (state_q == ST_ROUND) begin
			blk_q <= {blk_q[479:0], sched_w};
		end
		if (state_q == ST_ROUND) begin
			work_q <= work_nxt;
		end else if (byte_go && fill_q == FILL_LAST) begin
			work_q <= chain_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			fill_q     <= '0;
			msg_bits_q <= '0;
			round_q    <= '0;
			emit_idx_q <= '0;
			chain_q    <= sha1_pkg::H_INIT;
			fin_q      <= 1'b0;
			first_q    <= 1'b0;
			len_q      <= 1'b0;
			pad_done_q <= 1'b0;
		end else begin
			if (byte_go) begin
				fill_q <= fill_q + 6'd1;
				if (fill_q == FILL_LAST) begin
					state_q <= ST_ROUND;
					round_q <= '0;
				end
			end
			unique case (state_q)
				ST_IDLE: begin
					if (take) begin
						if (s_tuser) begin
							state_q <= ST_PAD;
							fin_q   <= 1'b1;
							first_q <= 1'b1;
							len_q   <= 1'b0;
						end else begin
							msg_bits_q <= msg_bits_q + 64'd8;
						end
					end
				end
				ST_PAD: begin
					first_q <= 1'b0;
					len_q   <= in_len;
					if (pad_last) begin
						pad_done_q <= 1'b1;
					end
				end
				ST_ROUND: begin
					round_q <= round_q + 7'd1;
					if (round_q == sha1_pkg::ROUND_LAST) begin
						state_q <= ST_ADD;
					end
				end
				ST_ADD: begin
					chain_q.a <= chain_q.a + work_q.a;
					chain_q.b <= chain_q.b + work_q.b;
					chain_q.c <= chain_q.c + work_q.c;
					chain_q.d <= chain_q.d + work_q.d;
					chain_q.e <= chain_q.e + work_q.e;
					round_q   <= '0;
					if (pad_done_q) begin
						state_q    <= ST_EMIT;
						emit_idx_q <= '0;
					end else if (fin_q) begin
						state_q <= ST_PAD;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (m_tready) begin
						if (emit_idx_q == WORD_IDX_LAST) begin
							state_q    <= ST_IDLE;
							chain_q    <= sha1_pkg::H_INIT;
							msg_bits_q <= '0;
							fin_q      <= 1'b0;
							pad_done_q <= 1'b0;
							emit_idx_q <= '0;
						end else begin
							// rotate the next digest word to the front
							chain_q    <= '{a: chain_q.b, b: chain_q.c, c: chain_q.d,
							                d: chain_q.e, e: chain_q.a};
							emit_idx_q <= emit_idx_q + 3'd1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_round_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND) |-> (round_q <= sha1_pkg::ROUND_LAST))
		else $error("round counter beyond last round");

	a_round_to_add: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND && round_q == sha1_pkg::ROUND_LAST) |=> (state_q == ST_ADD))
		else $error("compression did not end after the last round");

	a_add_fill_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ADD) |-> (fill_q == 6'd0))
		else $error("block buffer not empty when adding into the chain");

	a_emit_after_pad: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (fin_q && pad_done_q && fill_q == 6'd0))
		else $error("digest offered before padding finished");

	a_len_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PAD && in_len) |-> (fill_q >= FILL_LEN))
		else $error("length byte outside the last eight bytes of a block");
`endif

endmodule
